// ===== hw/rtl/mecf_pkg.sv =====
// shared types and constants of the mesh edge companion finder
`default_nettype none

package mecf_pkg;

   // fixed widths of the item fields
   localparam int CMD_BITS   = 2;
   localparam int POINT_BITS_FIELD = 16;
   localparam int EDGE_FIELD_BITS  = 10;

   // command codes
   localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_QUERY = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK_Q,
      ST_LOAD_QEND,
      ST_SCAN_A,
      ST_SCAN_B,
      ST_FINISH
   } state_type;

   // source of the shared store read address
   typedef enum logic [1:0] {
      ADDR_REQ,
      ADDR_LINK,
      ADDR_SCAN
   } addr_sel_type;

   // sequencer to datapath
   typedef struct packed {
      logic         busy;
      addr_sel_type addr_sel;
      logic         cap_q;
      logic         cap_qend;
      logic         cap_cand;
      logic         scan_init;
      logic         scan_step;
      logic         compare;
      logic         emit_err_req;
      logic         emit_err_held;
      logic         emit_result;
   } ctrl_type;

   // datapath to sequencer
   typedef struct packed {
      logic req_query;
      logic q_in_range;
      logic link_ok;
      logic scan_last;
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mecf_ram.sv =====
// generic single write, single read ram with registered read data
`default_nettype none

module mecf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mecf_seq.sv =====
// sequencer of the companion search
`default_nettype none

module mecf_seq
   import mecf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire status_type status,
   output ctrl_type        ctrl
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (status.req_query && status.q_in_range) begin
               state_in = ST_CHECK_Q;
            end
         end
         ST_CHECK_Q: begin
            if (status.link_ok) begin
               state_in = ST_LOAD_QEND;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LOAD_QEND: state_in = ST_SCAN_B;
         ST_SCAN_B: begin
            if (status.scan_last) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN_A;
            end
         end
         ST_SCAN_A:  state_in = ST_SCAN_B;
         ST_FINISH:  state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      ctrl = '0;
      ctrl.busy     = 1'b1;
      ctrl.addr_sel = ADDR_SCAN;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.busy         = 1'b0;
            ctrl.addr_sel     = ADDR_REQ;
            ctrl.emit_err_req = status.req_query && !status.q_in_range;
         end
         ST_CHECK_Q: begin
            // q start and q next arrive, fetch the start of q next
            ctrl.addr_sel      = ADDR_LINK;
            ctrl.cap_q         = 1'b1;
            ctrl.scan_init     = 1'b1;
            ctrl.emit_err_held = !status.link_ok;
         end
         ST_LOAD_QEND: begin
            ctrl.addr_sel = ADDR_SCAN;
            ctrl.cap_qend = 1'b1;
         end
         ST_SCAN_B: begin
            // candidate start and next arrive, fetch the candidate end
            ctrl.addr_sel  = ADDR_LINK;
            ctrl.cap_cand  = 1'b1;
            ctrl.scan_step = !status.scan_last;
         end
         ST_SCAN_A: begin
            ctrl.addr_sel = ADDR_SCAN;
            ctrl.compare  = 1'b1;
         end
         ST_FINISH: begin
            ctrl.compare     = 1'b1;
            ctrl.emit_result = 1'b1;
         end
         default: begin
            ctrl.busy = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mesh_edge_companion_finder_core.sv =====
// top level of the mesh edge companion finder: edge stores, search datapath, sequencer
//
// Clear and load items leave busy low, and a new item may follow at once. A
// query reads both edge stores through one shared read address; it first
// fetches the queried edge and its end point, then scans every loaded edge
// (start and next, then the start of the next edge) while holding busy high.
// A query whose edge or next edge is not below the loaded count answers
// with an index error. Each result is shown on the rsp_ ports for exactly
// one cycle under rsp_strobe and must be taken then; the receiver cannot
// stall the block.
`default_nettype none

module mesh_edge_companion_finder_core
   import mecf_pkg::*;
#(
   parameter int MAX_EDGES  = 1024,
   parameter int POINT_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [CMD_BITS-1:0]         req_command,
   input  wire logic [POINT_BITS_FIELD-1:0] req_start_point,
   input  wire logic [EDGE_FIELD_BITS-1:0]  req_next_edge,
   input  wire logic [EDGE_FIELD_BITS-1:0]  req_query_edge,
   output logic                             rsp_strobe,
   output logic [EDGE_FIELD_BITS-1:0]       rsp_companion_edge,
   output logic                             rsp_found,
   output logic                             rsp_index_error
);

   localparam int EDGE_BITS = $clog2(MAX_EDGES);
   localparam int CNT_BITS  = $clog2(MAX_EDGES + 1);
   localparam int WIDE_BITS = CNT_BITS + EDGE_FIELD_BITS;

   ctrl_type   ctrl;
   status_type status;
   logic       accept;

   // store ports
   logic                       store_we;
   logic [EDGE_BITS-1:0]       store_waddr;
   logic [EDGE_BITS-1:0]       store_raddr;
   logic [POINT_BITS-1:0]      start_wdata;
   logic [POINT_BITS-1:0]      rd_start;
   logic [EDGE_FIELD_BITS-1:0] rd_next;

   // widened helpers
   logic [POINT_BITS+POINT_BITS_FIELD-1:0] start_wide;
   logic [WIDE_BITS-1:0] req_q_wide;
   logic [WIDE_BITS-1:0] rd_next_wide;
   logic [WIDE_BITS-1:0] count_wide;
   logic [EDGE_BITS+EDGE_FIELD_BITS-1:0] best_wide;

   // search registers
   logic [CNT_BITS-1:0]        count_ff, count_in;
   logic [EDGE_FIELD_BITS-1:0] q_ff;
   logic [POINT_BITS-1:0]      q_start_ff;
   logic [POINT_BITS-1:0]      q_end_ff;
   logic [EDGE_BITS-1:0]       scan_ff, scan_in;
   logic [EDGE_BITS-1:0]       cand_idx_ff;
   logic [POINT_BITS-1:0]      cand_start_ff;
   logic                       cand_ok_ff;
   logic                       hit_ff, hit_in;
   logic [EDGE_BITS-1:0]       best_ff, best_in;
   logic                       match;

   // result registers
   logic                       rsp_strobe_ff, rsp_strobe_in;
   logic [EDGE_FIELD_BITS-1:0] rsp_edge_ff, rsp_edge_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic                       rsp_error_ff, rsp_error_in;

   assign busy   = ctrl.busy;
   assign accept = start && !ctrl.busy;

   // width adaption of fields and indices
   assign start_wide   = {{POINT_BITS{1'b0}}, req_start_point};
   assign start_wdata  = start_wide[POINT_BITS-1:0];
   assign req_q_wide   = {{CNT_BITS{1'b0}}, req_query_edge};
   assign rd_next_wide = {{CNT_BITS{1'b0}}, rd_next};
   assign count_wide   = {{EDGE_FIELD_BITS{1'b0}}, count_ff};

   // edge count: clear empties, load appends unless full
   always_comb begin
      count_in = count_ff;
      store_we = 1'b0;
      if (accept && req_command == CMD_CLEAR) begin
         count_in = '0;
      end else if (accept && req_command == CMD_LOAD
                   && count_ff != CNT_BITS'(MAX_EDGES)) begin
         count_in = count_ff + CNT_BITS'(1);
         store_we = 1'b1;
      end
   end

   assign store_waddr = count_ff[EDGE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // shared read address of both stores
   always_comb begin
      unique case (ctrl.addr_sel)
         ADDR_REQ:  store_raddr = req_q_wide[EDGE_BITS-1:0];
         ADDR_LINK: store_raddr = rd_next_wide[EDGE_BITS-1:0];
         ADDR_SCAN: store_raddr = scan_ff;
         default:   store_raddr = scan_ff;
      endcase
   end

   mecf_ram #(
      .WIDTH (POINT_BITS),
      .DEPTH (MAX_EDGES)
   ) u_start_store (
      .clock (clock),
      .we    (store_we),
      .waddr (store_waddr),
      .wdata (start_wdata),
      .raddr (store_raddr),
      .rdata (rd_start)
   );

   mecf_ram #(
      .WIDTH (EDGE_FIELD_BITS),
      .DEPTH (MAX_EDGES)
   ) u_next_store (
      .clock (clock),
      .we    (store_we),
      .waddr (store_waddr),
      .wdata (req_next_edge),
      .raddr (store_raddr),
      .rdata (rd_next)
   );

   // status towards the sequencer, a query request only counts while idle
   assign status.req_query  = start && req_command == CMD_QUERY;
   assign status.q_in_range = req_q_wide < count_wide;
   assign status.link_ok    = rd_next_wide < count_wide;
   assign status.scan_last  = ({1'b0, scan_ff} + (EDGE_BITS + 1)'(1))
                              == (EDGE_BITS + 1)'(count_ff);

   mecf_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // candidate runs from the query end back to the query start
   assign match = cand_ok_ff && cand_start_ff == q_end_ff && rd_start == q_start_ff;

   // running best match, highest index wins
   always_comb begin
      hit_in  = hit_ff;
      best_in = best_ff;
      if (ctrl.scan_init) begin
         hit_in = 1'b0;
      end else if (ctrl.compare && match) begin
         hit_in  = 1'b1;
         best_in = cand_idx_ff;
      end
   end

   // scan index
   always_comb begin
      scan_in = scan_ff;
      if (ctrl.scan_init) begin
         scan_in = '0;
      end else if (ctrl.scan_step) begin
         scan_in = scan_ff + EDGE_BITS'(1);
      end
   end

   // search payload registers
   always_ff @(posedge clock) begin
      if (accept && req_command == CMD_QUERY) begin
         q_ff <= req_query_edge;
      end
      if (ctrl.cap_q) begin
         q_start_ff <= rd_start;
      end
      if (ctrl.cap_qend) begin
         q_end_ff <= rd_start;
      end
      if (ctrl.cap_cand) begin
         cand_idx_ff   <= scan_ff;
         cand_start_ff <= rd_start;
         cand_ok_ff    <= rd_next_wide < count_wide;
      end
      scan_ff <= scan_in;
      hit_ff  <= hit_in;
      best_ff <= best_in;
   end

   assign best_wide = {{EDGE_FIELD_BITS{1'b0}}, best_in};

   // result selection
   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_edge_in   = rsp_edge_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_error_in  = rsp_error_ff;
      priority if (ctrl.emit_err_req) begin
         rsp_strobe_in = 1'b1;
         rsp_edge_in   = req_query_edge;
         rsp_found_in  = 1'b0;
         rsp_error_in  = 1'b1;
      end else if (ctrl.emit_err_held) begin
         rsp_strobe_in = 1'b1;
         rsp_edge_in   = q_ff;
         rsp_found_in  = 1'b0;
         rsp_error_in  = 1'b1;
      end else if (ctrl.emit_result) begin
         rsp_strobe_in = 1'b1;
         rsp_edge_in   = hit_in ? best_wide[EDGE_FIELD_BITS-1:0] : q_ff;
         rsp_found_in  = hit_in;
         rsp_error_in  = 1'b0;
      end else begin
         rsp_strobe_in = 1'b0;
      end
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_edge_ff  <= rsp_edge_in;
      rsp_found_ff <= rsp_found_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_companion_edge = rsp_edge_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_index_error    = rsp_error_ff;

endmodule

`default_nettype wire

// ===== dv/mesh_edge_companion_finder_core_test.sv =====
// testbench for the mesh edge companion finder: directed, full store and random mesh items
`timescale 1ns / 1ps

module mesh_edge_companion_finder_core_test;
   import mecf_pkg::*;

   // a small store so that the full case is reached quickly
   localparam int MAX_EDGES = 64;
   // the one command code that the block ignores
   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [EDGE_FIELD_BITS-1:0] companion;
      logic                       found;
      logic                       index_error;
   } companion_answer_type;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [CMD_BITS-1:0]         req_command;
   logic [POINT_BITS_FIELD-1:0] req_start_point;
   logic [EDGE_FIELD_BITS-1:0]  req_next_edge;
   logic [EDGE_FIELD_BITS-1:0]  req_query_edge;
   logic                        rsp_strobe;
   logic [EDGE_FIELD_BITS-1:0]  rsp_companion_edge;
   logic                        rsp_found;
   logic                        rsp_index_error;

   // own copy of the edge stores
   logic [POINT_BITS_FIELD-1:0] mesh_start_pt [MAX_EDGES];
   logic [EDGE_FIELD_BITS-1:0]  mesh_next_ix [MAX_EDGES];
   int                          mesh_edge_count;

   companion_answer_type companion_expect_q [$];
   int                   mismatch_count;
   int                   items_sent;
   int                   sender_idle_pct;

   mesh_edge_companion_finder_core #(
      .MAX_EDGES (MAX_EDGES)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_start_point    (req_start_point),
      .req_next_edge      (req_next_edge),
      .req_query_edge     (req_query_edge),
      .rsp_strobe         (rsp_strobe),
      .rsp_companion_edge (rsp_companion_edge),
      .rsp_found          (rsp_found),
      .rsp_index_error    (rsp_index_error)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("mismatch at %0t ns: %s", $time, what);
      end
   endtask

   // update the edge stores and work out the answer for an accepted item
   task automatic predict_companion(input logic [CMD_BITS-1:0] cmd,
                                    input logic [POINT_BITS_FIELD-1:0] pt,
                                    input logic [EDGE_FIELD_BITS-1:0] nxt,
                                    input logic [EDGE_FIELD_BITS-1:0] qe);
      companion_answer_type        ans;
      logic [POINT_BITS_FIELD-1:0] q_start;
      logic [POINT_BITS_FIELD-1:0] q_end;
      logic [EDGE_FIELD_BITS-1:0]  scan_next;
      int                          scan_ix;
      case (cmd)
         CMD_CLEAR: begin
            mesh_edge_count = 0;
         end
         CMD_LOAD: begin
            // a full store drops the item
            if (mesh_edge_count < MAX_EDGES) begin
               mesh_start_pt[mesh_edge_count] = pt;
               mesh_next_ix[mesh_edge_count]  = nxt;
               mesh_edge_count++;
            end
         end
         CMD_QUERY: begin
            ans.companion   = qe;
            ans.found       = 1'b0;
            ans.index_error = 1'b0;
            if (qe >= mesh_edge_count || mesh_next_ix[qe] >= mesh_edge_count) begin
               ans.index_error = 1'b1;
            end else begin
               q_start = mesh_start_pt[qe];
               q_end   = mesh_start_pt[mesh_next_ix[qe]];
               // later hits overwrite earlier ones; edges with a dangling link never match
               for (scan_ix = 0; scan_ix < mesh_edge_count; scan_ix++) begin
                  scan_next = mesh_next_ix[scan_ix];
                  if (scan_next < mesh_edge_count && mesh_start_pt[scan_ix] == q_end &&
                      mesh_start_pt[scan_next] == q_start) begin
                     ans.companion = scan_ix[EDGE_FIELD_BITS-1:0];
                     ans.found     = 1'b1;
                  end
               end
            end
            companion_expect_q = {companion_expect_q, ans};
         end
         default: begin
         end
      endcase
   endtask

   // drive one item, wait for it to be taken, then maybe idle with junk on the fields
   task automatic send_item(input logic [CMD_BITS-1:0] cmd,
                            input logic [POINT_BITS_FIELD-1:0] pt,
                            input logic [EDGE_FIELD_BITS-1:0] nxt,
                            input logic [EDGE_FIELD_BITS-1:0] qe);
      int gap;
      req_command     <= cmd;
      req_start_point <= pt;
      req_next_edge   <= nxt;
      req_query_edge  <= qe;
      start           <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predict_companion(cmd, pt, nxt, qe);
      if (cmd != CMD_UNUSED) items_sent++;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 4);
         repeat (gap) begin
            req_command     <= CMD_BITS'($urandom);
            req_start_point <= POINT_BITS_FIELD'($urandom);
            req_next_edge   <= EDGE_FIELD_BITS'($urandom);
            req_query_edge  <= EDGE_FIELD_BITS'($urandom);
            @(posedge clock);
         end
      end
   endtask

   // check each result against the oldest answer waiting
   always @(posedge clock) begin
      companion_answer_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (companion_expect_q.size() == 0) begin
            report_mismatch("result with no query waiting");
         end else begin
            want = companion_expect_q.pop_front();
            if (rsp_companion_edge !== want.companion)
               report_mismatch($sformatf("companion_edge got %0d want %0d",
                                         rsp_companion_edge, want.companion));
            if (rsp_found !== want.found)
               report_mismatch($sformatf("found got %b want %b", rsp_found, want.found));
            if (rsp_index_error !== want.index_error)
               report_mismatch($sformatf("index_error got %b want %b",
                                         rsp_index_error, want.index_error));
         end
      end
   end

   // hand-built mesh covering each corner case
   task automatic directed_cases();
      send_item(CMD_CLEAR, 16'h0000, 10'd0, 10'd0);
      // query on an empty store
      send_item(CMD_QUERY, 16'hFFFF, 10'd1023, 10'd0);
      // a loop 0 -> ffff -> 0, a second copy of it, a self-loop and a dangling link
      send_item(CMD_LOAD, 16'h0000, 10'd1, 10'd1023);
      send_item(CMD_LOAD, 16'hFFFF, 10'd0, 10'd0);
      send_item(CMD_LOAD, 16'hFFFF, 10'd3, 10'd0);
      send_item(CMD_LOAD, 16'h0000, 10'd2, 10'd0);
      send_item(CMD_LOAD, 16'h1234, 10'd4, 10'd0);
      send_item(CMD_LOAD, 16'h00FF, 10'd1023, 10'd0);
      send_item(CMD_LOAD, 16'h0000, 10'd5, 10'd0);
      // several matches, highest index wins
      send_item(CMD_QUERY, 16'h0000, 10'd0, 10'd0);
      send_item(CMD_QUERY, 16'h0000, 10'd0, 10'd1);
      // self-loop is its own companion
      send_item(CMD_QUERY, 16'h0000, 10'd0, 10'd4);
      // queried edge links past the loaded count
      send_item(CMD_QUERY, 16'h0000, 10'd0, 10'd5);
      // only candidate has a dangling link, so no match
      send_item(CMD_QUERY, 16'h0000, 10'd0, 10'd6);
      send_item(CMD_QUERY, 16'h0000, 10'd0, 10'd1023);
      // unused command must leave the store alone
      send_item(CMD_UNUSED, 16'hFFFF, 10'd1023, 10'd1023);
      send_item(CMD_QUERY, 16'hFFFF, 10'd1023, 10'd3);
      // clear then reuse
      send_item(CMD_CLEAR, 16'hFFFF, 10'd1023, 10'd1023);
      send_item(CMD_QUERY, 16'h0000, 10'd0, 10'd0);
      send_item(CMD_LOAD, 16'hFFFF, 10'd1023, 10'd0);
      send_item(CMD_QUERY, 16'h0000, 10'd0, 10'd0);
   endtask

   // fill every slot, try loads past the end, query the extreme indices
   task automatic full_store_cases();
      logic [POINT_BITS_FIELD-1:0] pool [4];
      int                          slot;
      pool[0] = 16'h0000;
      pool[1] = POINT_BITS_FIELD'($urandom);
      pool[2] = POINT_BITS_FIELD'($urandom);
      pool[3] = 16'hFFFF;
      send_item(CMD_CLEAR, 16'h0000, 10'd0, 10'd0);
      // pairs of edges linked to each other, points from a small pool
      for (slot = 0; slot < MAX_EDGES; slot++) begin
         send_item(CMD_LOAD, pool[$urandom_range(0, 3)], 10'(slot ^ 1),
                   EDGE_FIELD_BITS'($urandom));
      end
      send_item(CMD_LOAD, 16'hABCD, 10'd0, 10'd0);
      send_item(CMD_LOAD, 16'h5555, 10'd1023, 10'd1023);
      send_item(CMD_QUERY, POINT_BITS_FIELD'($urandom), EDGE_FIELD_BITS'($urandom),
                10'(MAX_EDGES - 1));
      send_item(CMD_QUERY, POINT_BITS_FIELD'($urandom), EDGE_FIELD_BITS'($urandom), 10'd0);
      send_item(CMD_QUERY, POINT_BITS_FIELD'($urandom), EDGE_FIELD_BITS'($urandom),
                10'(MAX_EDGES - 2));
      send_item(CMD_QUERY, POINT_BITS_FIELD'($urandom), EDGE_FIELD_BITS'($urandom),
                EDGE_FIELD_BITS'($urandom));
      send_item(CMD_CLEAR, POINT_BITS_FIELD'($urandom), EDGE_FIELD_BITS'($urandom),
                EDGE_FIELD_BITS'($urandom));
   endtask

   // random polygons over a small point pool so that companions are common
   task automatic random_mesh_sessions(input int target, input int idle_pct);
      logic [POINT_BITS_FIELD-1:0] pool [6];
      logic [POINT_BITS_FIELD-1:0] verts [5];
      int                          pool_n;
      int                          poly_n;
      int                          base;
      int                          k;
      int                          roll;
      int                          sent0;
      sender_idle_pct = idle_pct;
      sent0 = items_sent;
      while (items_sent - sent0 < target) begin
         if (mesh_edge_count > 40 || $urandom_range(0, 3) == 0)
            send_item(CMD_CLEAR, POINT_BITS_FIELD'($urandom), EDGE_FIELD_BITS'($urandom),
                      EDGE_FIELD_BITS'($urandom));
         pool_n = $urandom_range(2, 6);
         for (k = 0; k < pool_n; k++) begin
            roll = $urandom_range(0, 9);
            pool[k] = (roll == 0) ? 16'h0000 : (roll == 1) ? 16'hFFFF : 16'($urandom);
         end
         // polygons; size one gives a self-loop
         repeat ($urandom_range(1, 4)) begin
            poly_n = $urandom_range(1, 5);
            base   = mesh_edge_count;
            for (k = 0; k < poly_n; k++) verts[k] = pool[$urandom_range(0, pool_n - 1)];
            for (k = 0; k < poly_n; k++) begin
               roll = $urandom_range(0, 99);
               if (roll < 6) begin
                  // broken link
                  send_item(CMD_LOAD, verts[k], EDGE_FIELD_BITS'($urandom),
                            EDGE_FIELD_BITS'($urandom));
               end else begin
                  if (roll < 10)
                     send_item(CMD_UNUSED, POINT_BITS_FIELD'($urandom),
                               EDGE_FIELD_BITS'($urandom), EDGE_FIELD_BITS'($urandom));
                  send_item(CMD_LOAD, verts[k], 10'(base + (k + 1) % poly_n),
                            EDGE_FIELD_BITS'($urandom));
               end
            end
         end
         // queries, mostly on loaded edges
         repeat ($urandom_range(2, 6)) begin
            if ($urandom_range(0, 99) < 82 && mesh_edge_count > 0)
               send_item(CMD_QUERY, POINT_BITS_FIELD'($urandom), EDGE_FIELD_BITS'($urandom),
                         EDGE_FIELD_BITS'($urandom_range(0, mesh_edge_count - 1)));
            else
               send_item(CMD_QUERY, POINT_BITS_FIELD'($urandom), EDGE_FIELD_BITS'($urandom),
                         EDGE_FIELD_BITS'($urandom));
         end
      end
   endtask

   // main sequence
   initial begin
      mismatch_count  = 0;
      items_sent      = 0;
      mesh_edge_count = 0;
      sender_idle_pct = 38;
      reset           <= 1'b1;
      start           <= 1'b0;
      req_command     <= CMD_CLEAR;
      req_start_point <= '0;
      req_next_edge   <= '0;
      req_query_edge  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      directed_cases();
      full_store_cases();
      random_mesh_sessions(55, 38);
      random_mesh_sessions(55, 68);
      random_mesh_sessions(55, 0);
      start <= 1'b0;

      // let outstanding answers arrive, then watch for strays
      while (companion_expect_q.size() != 0) @(posedge clock);
      repeat (2 * MAX_EDGES + 8) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
